/* rtl/three_stop_gradient_pixel_assert.svh */
// Assertion macros shared by the gradient pixel RTL.
`ifndef THREE_STOP_GRADIENT_PIXEL_ASSERT_SVH
`define THREE_STOP_GRADIENT_PIXEL_ASSERT_SVH

// Check that an antecedent implies a consequent in the same cycle.
`define TSGP_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tsgp assertion failed");

// Check that an antecedent implies a consequent in the next cycle.
`define TSGP_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tsgp assertion failed");

`endif

/* rtl/tsgp_pkg.sv */
// Types and constants shared by the gradient pixel modules.
package tsgp_pkg;

   localparam int MAX_STEPS   = 4096;
   localparam int IDX_W       = 12;
   localparam int CNT_W       = 13;
   localparam int CHAN_W      = 8;
   localparam int NUM_CHANS   = 4;
   localparam int REM_W       = 19;
   localparam int DIV_STAGES  = 4;
   localparam int BITS_PER_ST = 2;
   localparam int ADDR_W      = 5;
   // setup, multiply, then the divider stages
   localparam int LATENCY     = 2 + DIV_STAGES;

   typedef enum logic [2:0] {
      REG_START      = 3'd0,
      REG_MIDDLE     = 3'd1,
      REG_END        = 3'd2,
      REG_STEP_COUNT = 3'd3,
      REG_HORIZONTAL = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [31:0]      start_colour;
      logic [31:0]      middle_colour;
      logic [31:0]      end_colour;
      logic [CNT_W-1:0] step_count;
      logic             horizontal;
   } cfg_type;

   // Payload carried down the divider stages
   typedef struct packed {
      logic                                oor;
      logic [IDX_W-1:0]                    pos;
      logic [IDX_W-1:0]                    span;
      logic [NUM_CHANS-1:0][REM_W-1:0]     rem;
      logic [NUM_CHANS-1:0][CHAN_W-1:0]    quo;
   } item_type;

endpackage

/* rtl/tsgp_front.sv */
// Setup and multiply stages: weights, span, position and blend numerators.
module tsgp_front import tsgp_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [IDX_W-1:0] in_index,
   input  cfg_type          cfg,
   output logic             out_valid,
   output item_type         out_item
);

   localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_STEPS);

   logic [CNT_W-1:0] n_sat;
   logic [IDX_W-1:0] mid;
   logic [CNT_W-1:0] idx_ext;
   logic             low_half;

   logic                              a_valid_ff, a_valid_in;
   logic                              a_oor_ff, a_oor_in;
   logic [IDX_W-1:0]                  a_pos_ff, a_pos_in;
   logic [IDX_W-1:0]                  a_span_ff, a_span_in;
   logic [IDX_W-1:0]                  a_wa_ff, a_wa_in;
   logic [IDX_W-1:0]                  a_wb_ff, a_wb_in;
   logic [31:0]                       a_ca_ff, a_ca_in;
   logic [31:0]                       a_cb_ff, a_cb_in;

   logic                              b_valid_ff;
   item_type                          b_item_ff, b_item_in;

   // Saturate the count and pick the half of the ramp
   always_comb begin
      if (cfg.step_count < CNT_W'(2)) begin
         n_sat = CNT_W'(2);
      end else if (cfg.step_count > MAX_N) begin
         n_sat = MAX_N;
      end else begin
         n_sat = cfg.step_count;
      end
      mid      = n_sat[CNT_W-1:1];
      idx_ext  = {1'b0, in_index};
      low_half = in_index < mid;

      a_valid_in = in_valid;
      a_oor_in   = idx_ext >= n_sat;
      if (cfg.horizontal) begin
         a_pos_in = in_index;
      end else begin
         a_pos_in = IDX_W'(n_sat - CNT_W'(1) - idx_ext);
      end
      if (low_half) begin
         a_span_in = mid;
         a_wa_in   = mid - in_index;
         a_wb_in   = in_index;
         a_ca_in   = cfg.start_colour;
         a_cb_in   = cfg.middle_colour;
      end else begin
         a_span_in = IDX_W'(n_sat - {1'b0, mid});
         a_wa_in   = IDX_W'(n_sat - idx_ext);
         a_wb_in   = in_index - mid;
         a_ca_in   = cfg.middle_colour;
         a_cb_in   = cfg.end_colour;
      end
   end

   // Form the numerators, zero for an index past the ramp
   always_comb begin
      b_item_in.oor  = a_oor_ff;
      b_item_in.pos  = a_oor_ff ? '0 : a_pos_ff;
      b_item_in.span = a_span_ff;
      for (int k = 0; k < NUM_CHANS; k++) begin
         logic [CHAN_W-1:0]        ca;
         logic [CHAN_W-1:0]        cb;
         logic [CHAN_W+IDX_W-1:0]  sum;
         ca  = a_ca_ff[(NUM_CHANS-1-k)*CHAN_W +: CHAN_W];
         cb  = a_cb_ff[(NUM_CHANS-1-k)*CHAN_W +: CHAN_W];
         sum = (CHAN_W+IDX_W)'(ca * a_wa_ff) + (CHAN_W+IDX_W)'(cb * a_wb_ff);
         b_item_in.rem[k] = a_oor_ff ? '0 : sum[REM_W-1:0];
         b_item_in.quo[k] = '0;
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= a_valid_ff;
      end
   end

   // Hold payload
   always_ff @(posedge clock) begin
      a_oor_ff  <= a_oor_in;
      a_pos_ff  <= a_pos_in;
      a_span_ff <= a_span_in;
      a_wa_ff   <= a_wa_in;
      a_wb_ff   <= a_wb_in;
      a_ca_ff   <= a_ca_in;
      a_cb_ff   <= a_cb_in;
      b_item_ff <= b_item_in;
   end

   assign out_valid = b_valid_ff;
   assign out_item  = b_item_ff;

endmodule

/* rtl/tsgp_div.sv */
// One divider stage: two restoring quotient bits per channel.
module tsgp_div import tsgp_pkg::*; #(
   parameter int LOW_BIT = 0
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  item_type in_item,
   output logic     out_valid,
   output item_type out_item
);

   logic     valid_ff;
   item_type item_ff, item_in;

   // Subtract the shifted span where it fits, high bit first
   always_comb begin
      item_in = in_item;
      for (int k = 0; k < NUM_CHANS; k++) begin
         for (int b = BITS_PER_ST - 1; b >= 0; b--) begin
            logic [REM_W-1:0] dv;
            dv = REM_W'({{(REM_W-IDX_W){1'b0}}, in_item.span} << (LOW_BIT + b));
            if (item_in.rem[k] >= dv) begin
               item_in.rem[k] = item_in.rem[k] - dv;
               item_in.quo[k][LOW_BIT + b] = 1'b1;
            end
         end
      end
   end

   // Advance valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   // Hold payload
   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

/* rtl/three_stop_gradient_pixel.sv */
// Three-stop linear gradient pixel generator: register file and pipeline.
//
// Accepts one step index per cycle (busy is never high) and returns one result
// per index, marked by rsp_valid. The result passes through one setup stage, one
// multiply stage and a four-stage restoring divider that resolves two quotient
// bits per stage. Results cannot be held off; the registers are to be written
// only while no item is in flight.
`include "three_stop_gradient_pixel_assert.svh"

module three_stop_gradient_pixel import tsgp_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [IDX_W-1:0]    req_step_index,
   output logic                rsp_valid,
   output logic [IDX_W-1:0]    rsp_pixel_position,
   output logic [CHAN_W-1:0]   rsp_alpha,
   output logic [CHAN_W-1:0]   rsp_red,
   output logic [CHAN_W-1:0]   rsp_green,
   output logic [CHAN_W-1:0]   rsp_blue,
   output logic                rsp_out_of_range,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [ADDR_W-1:0]   paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   cfg_type       cfg_ff, cfg_in;
   reg_index_type reg_sel;
   logic          wr_en;
   logic          accept;

   logic     [DIV_STAGES:0] stg_valid;
   item_type [DIV_STAGES:0] stg_item;

   assign busy   = 1'b0;
   assign pready = 1'b1;
   assign accept = start && !busy;
   assign wr_en  = psel && penable && pwrite && pready;

   // Decode register writes
   always_comb begin
      cfg_in  = cfg_ff;
      reg_sel = reg_index_type'(paddr[ADDR_W-1:2]);
      if (wr_en) begin
         unique case (paddr[ADDR_W-1:2])
            REG_START:      cfg_in.start_colour  = pwdata;
            REG_MIDDLE:     cfg_in.middle_colour = pwdata;
            REG_END:        cfg_in.end_colour    = pwdata;
            REG_STEP_COUNT: cfg_in.step_count    = pwdata[CNT_W-1:0];
            REG_HORIZONTAL: cfg_in.horizontal    = pwdata[0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   // Decode register reads
   always_comb begin
      unique case (reg_sel)
         REG_START:      prdata = cfg_ff.start_colour;
         REG_MIDDLE:     prdata = cfg_ff.middle_colour;
         REG_END:        prdata = cfg_ff.end_colour;
         REG_STEP_COUNT: prdata = {{(32-CNT_W){1'b0}}, cfg_ff.step_count};
         REG_HORIZONTAL: prdata = {31'd0, cfg_ff.horizontal};
         default:        prdata = '0;
      endcase
   end

   // Hold configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_colour  <= '0;
         cfg_ff.middle_colour <= '0;
         cfg_ff.end_colour    <= '0;
         cfg_ff.step_count    <= CNT_W'(2);
         cfg_ff.horizontal    <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   tsgp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_index  (req_step_index),
      .cfg       (cfg_ff),
      .out_valid (stg_valid[0]),
      .out_item  (stg_item[0])
   );

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
      tsgp_div #(
         .LOW_BIT ((DIV_STAGES - 1 - s) * BITS_PER_ST)
      ) u_div (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (stg_valid[s]),
         .in_item   (stg_item[s]),
         .out_valid (stg_valid[s+1]),
         .out_item  (stg_item[s+1])
      );
   end

   assign rsp_valid          = stg_valid[DIV_STAGES];
   assign rsp_pixel_position = stg_item[DIV_STAGES].pos;
   assign rsp_alpha          = stg_item[DIV_STAGES].quo[0];
   assign rsp_red            = stg_item[DIV_STAGES].quo[1];
   assign rsp_green          = stg_item[DIV_STAGES].quo[2];
   assign rsp_blue           = stg_item[DIV_STAGES].quo[3];
   assign rsp_out_of_range   = stg_item[DIV_STAGES].oor;

   `TSGP_ASSERT_IMP(a_rsp_has_item, clock, reset, rsp_valid, $past(accept, LATENCY))
   `TSGP_ASSERT_IMP(a_item_gets_rsp, clock, reset, accept, ##LATENCY rsp_valid)
   `TSGP_ASSERT_IMP(a_oor_blank, clock, reset, rsp_valid && rsp_out_of_range, (rsp_alpha == '0) && (rsp_red == '0) && (rsp_green == '0) && (rsp_blue == '0) && (rsp_pixel_position == '0))

endmodule

/* sim/three_stop_gradient_pixel_test.sv */
// Self-checking testbench for the three-stop gradient pixel generator.
module three_stop_gradient_pixel_test import tsgp_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct {
      logic [IDX_W-1:0]  pos;
      logic [CHAN_W-1:0] a, r, g, b;
      logic              oor;
   } pixel_type;

   // Directed rows: register settings, index, optional typed-in result
   typedef struct {
      logic [31:0]       c0, c1, c2;
      logic [CNT_W-1:0]  cnt;
      logic              horiz;
      logic [IDX_W-1:0]  idx;
      logic              typed;
      pixel_type         px;
   } row_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [IDX_W-1:0]   req_step_index;
   logic               rsp_valid;
   logic [IDX_W-1:0]   rsp_pixel_position;
   logic [CHAN_W-1:0]  rsp_alpha, rsp_red, rsp_green, rsp_blue;
   logic               rsp_out_of_range;
   logic               psel, penable, pwrite;
   logic [ADDR_W-1:0]  paddr;
   logic [31:0]        pwdata;
   logic [31:0]        prdata;
   logic               pready;

   three_stop_gradient_pixel dut (.*);

   // Shadow of the register file
   logic [31:0]       sh_start, sh_middle, sh_end;
   logic [CNT_W-1:0]  sh_count;
   logic              sh_horiz;

   pixel_type  pending_pixels[$];
   int         error_count;
   int         stall_cycles;
   int         send_idle_pct;

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic logic [CHAN_W-1:0] mix(input logic [7:0] a, input int unsigned wa,
                                              input logic [7:0] b, input int unsigned wb,
                                              input int unsigned span);
      longint unsigned q;
      q = (longint'(a) * wa + longint'(b) * wb) / span;
      return (q > 255) ? 8'hFF : q[7:0];
   endfunction

   // Compute the expected pixel from the shadow registers
   function automatic pixel_type gradient_pixel(input logic [IDX_W-1:0] idx);
      pixel_type    px;
      int unsigned  n, m, i, sh;
      logic [7:0]   ch[4];
      n = sh_count;
      if (n < 2) n = 2;
      if (n > MAX_STEPS) n = MAX_STEPS;
      m = n / 2;
      i = idx;
      px = '{default: '0};
      if (i >= n) begin
         px.oor = 1'b1;
         return px;
      end
      px.pos = sh_horiz ? IDX_W'(i) : IDX_W'(n - 1 - i);
      for (int k = 0; k < 4; k++) begin
         sh = 24 - 8 * k;
         if (i < m)
            ch[k] = mix(8'(sh_start >> sh), m - i, 8'(sh_middle >> sh), i, m);
         else
            ch[k] = mix(8'(sh_middle >> sh), n - i, 8'(sh_end >> sh), i - m, n - m);
      end
      px.a = ch[0];
      px.r = ch[1];
      px.g = ch[2];
      px.b = ch[3];
      return px;
   endfunction

   task automatic write_reg(input reg_index_type which, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= ADDR_W'(4 * which);
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (which)
         REG_START:      sh_start = value;
         REG_MIDDLE:     sh_middle = value;
         REG_END:        sh_end = value;
         REG_STEP_COUNT: sh_count = value[CNT_W-1:0];
         default:        sh_horiz = value[0];
      endcase
   endtask

   // Wait for the pipeline to drain before touching registers
   task automatic drain();
      int guard;
      guard = 0;
      while (pending_pixels.size() != 0 && guard < WATCHDOG_LIMIT) begin
         @(posedge clock);
         guard++;
      end
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   task automatic configure(input logic [31:0] c0, input logic [31:0] c1,
                            input logic [31:0] c2, input logic [31:0] cnt,
                            input logic h);
      // Drop start so no item slips in while draining
      start <= 1'b0;
      drain();
      write_reg(REG_START, c0);
      write_reg(REG_MIDDLE, c1);
      write_reg(REG_END, c2);
      write_reg(REG_STEP_COUNT, cnt);
      write_reg(REG_HORIZONTAL, {31'b0, h});
   endtask

   // Present one index, optionally with random gaps, until accepted
   task automatic send_index(input logic [IDX_W-1:0] idx);
      while ($urandom_range(99) < send_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_step_index <= idx;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_pixels.push_back(gradient_pixel(idx));
   endtask

   // Compare each strobed result with the oldest expectation
   always @(posedge clock) begin
      pixel_type want;
      if (!reset && ((start && !busy) || rsp_valid)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (!reset && rsp_valid) begin
         if (pending_pixels.size() == 0) begin
            $display("unexpected result at %0t", $realtime);
            error_count++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_pixel_position !== want.pos)
               report("pixel_position", rsp_pixel_position, want.pos);
            if (rsp_alpha !== want.a) report("alpha", rsp_alpha, want.a);
            if (rsp_red !== want.r) report("red", rsp_red, want.r);
            if (rsp_green !== want.g) report("green", rsp_green, want.g);
            if (rsp_blue !== want.b) report("blue", rsp_blue, want.b);
            if (rsp_out_of_range !== want.oor)
               report("out_of_range", rsp_out_of_range, want.oor);
         end
      end
   end

   // Watchdog on cycles with no handshake
   always @(posedge clock) begin
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL three_stop_gradient_pixel");
         $finish;
      end
   end

   function automatic logic [31:0] rand_colour();
      case ($urandom_range(3))
         0:       return 32'h0;
         1:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] rand_count();
      case ($urandom_range(9))
         0:       return $urandom_range(0, 1);
         1:       return $urandom_range(4097, 8191);
         2:       return 4096;
         3:       return $urandom_range(2, 4096);
         default: return $urandom_range(2, 40);
      endcase
   endfunction

   row_type rows[$];

   initial begin
      row_type     rw;
      int unsigned n;
      int          sent;
      logic [IDX_W-1:0] idx;
      error_count = 0;
      stall_cycles = 0;
      send_idle_pct = 0;
      reset <= 1'b1;
      start <= 1'b0;
      req_step_index <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      sh_start = 0;
      sh_middle = 0;
      sh_end = 0;
      sh_count = 2;
      sh_horiz = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // After reset: black, two steps, vertical
      rows.push_back('{0, 0, 0, 2, 0, 0, 1, '{12'd1, 0, 0, 0, 0, 0}});
      rows.push_back('{0, 0, 0, 2, 0, 1, 1, '{12'd0, 0, 0, 0, 0, 0}});
      rows.push_back('{0, 0, 0, 2, 0, 12'hFFF, 1, '{0, 0, 0, 0, 0, 1}});
      // Extremes of colour at the stops
      rows.push_back('{32'hFFFF_FFFF, 0, 32'h1234_5678, 9, 1, 0, 1,
                       '{12'd0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 0}});
      rows.push_back('{32'hFFFF_FFFF, 0, 32'h1234_5678, 9, 1, 4, 1, '{12'd4, 0, 0, 0, 0, 0}});
      rows.push_back('{32'hFFFF_FFFF, 0, 32'h1234_5678, 9, 1, 8, 0, '{default: '0}});
      rows.push_back('{32'hFFFF_FFFF, 0, 32'h1234_5678, 9, 1, 9, 1, '{0, 0, 0, 0, 0, 1}});
      // Odd and even counts around the midpoint
      rows.push_back('{32'h0000_00FF, 32'hFFFF_FFFF, 32'hFF00_0000, 7, 0, 3, 0, '{default: '0}});
      rows.push_back('{32'h0000_00FF, 32'hFFFF_FFFF, 32'hFF00_0000, 7, 0, 2, 0, '{default: '0}});
      rows.push_back('{32'h0000_00FF, 32'hFFFF_FFFF, 32'hFF00_0000, 6, 1, 5, 0, '{default: '0}});
      // Step count below two and above the maximum saturate
      rows.push_back('{32'hFFFF_FFFF, 32'h8080_8080, 0, 0, 1, 1, 0, '{default: '0}});
      rows.push_back('{32'hFFFF_FFFF, 32'h8080_8080, 0, 1, 0, 2, 1, '{0, 0, 0, 0, 0, 1}});
      rows.push_back('{32'hFFFF_FFFF, 32'h8080_8080, 0, 8191, 1, 12'hFFF, 0, '{default: '0}});
      rows.push_back('{32'hFFFF_FFFF, 32'h8080_8080, 0, 4096, 0, 12'hFFF, 0, '{default: '0}});
      rows.push_back('{32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'hFFFF_FFFF, 4096, 0, 12'd2048, 0,
                       '{default: '0}});
      rows.push_back('{32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'hFFFF_FFFF, 4095, 1, 12'hFFF, 1,
                       '{0, 0, 0, 0, 0, 1}});
      rows.push_back('{32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'hFFFF_FFFF, 4095, 1, 12'd2047, 0,
                       '{default: '0}});

      // Walk the directed rows; typed results override the predictor
      foreach (rows[i]) begin
         rw = rows[i];
         if (i == 0 || rw.c0 != sh_start || rw.c1 != sh_middle || rw.c2 != sh_end ||
             rw.cnt != sh_count || rw.horiz != sh_horiz)
            configure(rw.c0, rw.c1, rw.c2, rw.cnt, rw.horiz);
         send_index(rw.idx);
         if (rw.typed) begin
            void'(pending_pixels.pop_back());
            pending_pixels.push_back(rw.px);
         end
      end
      start <= 1'b0;

      // Random phases: sender idles, then steady stream
      sent = 0;
      while (sent < 1950) begin
         configure(rand_colour(), rand_colour(), rand_colour(), rand_count(), $urandom_range(1));
         send_idle_pct = (sent < 650) ? 16 : (sent < 1300) ? 55 : 0;
         n = (sh_count < 2) ? 2 : (sh_count > MAX_STEPS) ? MAX_STEPS : sh_count;
         repeat ($urandom_range(20, 80)) begin
            if ($urandom_range(9) == 0) idx = IDX_W'($urandom);
            else idx = IDX_W'($urandom_range(0, n - 1));
            send_index(idx);
            sent++;
         end
         start <= 1'b0;
      end

      drain();
      if (error_count == 0)
         $display("PASS three_stop_gradient_pixel");
      else
         $display("FAIL three_stop_gradient_pixel");
      $finish;
   end

endmodule
